/* rtl/lstmp_pkg.sv */
`timescale 1ns / 1ps
package lstmp_pkg;

  localparam int MAX_INPUT_DEF  = 64;
  localparam int MAX_HIDDEN_DEF = 64;
  localparam int MAX_PROJ_DEF   = 64;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int CNT_W  = 7;
  localparam int IDX_W  = 14;
  localparam int VAL_W  = 16;
  localparam int OIDX_W = 6;
  localparam int ACC_W  = 44;
  localparam int TAB_N  = 1024;
  localparam int TAB_AW = 10;
  localparam int EXP_N  = 2047;
  localparam logic [31:0] EXP_STEP = 32'd2130771798;
  localparam logic [63:0] ONE31    = 64'h0000_0000_8000_0000;

  localparam logic [1:0] REG_INPUT  = 2'd0;
  localparam logic [1:0] REG_HIDDEN = 2'd1;
  localparam logic [1:0] REG_PROJ   = 2'd2;

  typedef enum logic [2:0] {
    FN_IN_W    = 3'd0,
    FN_REC_W   = 3'd1,
    FN_PROJ_W  = 3'd2,
    FN_BIAS    = 3'd3,
    FN_INIT_P  = 3'd4,
    FN_INIT_C  = 3'd5,
    FN_SAMPLE  = 3'd6,
    FN_READ_C  = 3'd7
  } func_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BIAS,
    OP_MAC_IN,
    OP_MAC_REC,
    OP_SAVE_PRE,
    OP_LUT,
    OP_CELL_A,
    OP_CELL_B,
    OP_SAVE_C,
    OP_TANH_C,
    OP_HID,
    OP_SAVE_H,
    OP_MAC_PW,
    OP_SAVE_Y,
    OP_RD_CELL
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDC,
    ST_BIAS,
    ST_IN,
    ST_REC,
    ST_GSAV,
    ST_ACT,
    ST_CA,
    ST_CB,
    ST_CSAV,
    ST_TC,
    ST_HID,
    ST_HSAV,
    ST_PGAP,
    ST_PMAC,
    ST_PSAV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              wr;
    op_e               op;
    logic [1:0]        g;
    logic [CNT_W-1:0]  u;
    logic [CNT_W-1:0]  i;
    logic [CNT_W-1:0]  q;
    logic              lst;
    logic [IDX_W-1:0]  ridx;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  typedef logic signed [15:0] tab_t [TAB_N];

  function automatic logic signed [15:0] sat_round(input logic signed [ACC_W-1:0] a,
                                                   input int frac);
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] s;
    h = '0;
    h[frac-1] = 1'b1;
    s = a + h;
    s = s >>> frac;
    if (s > 44'sd32767) begin
      return 16'sh7fff;
    end else if (s < -44'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  function automatic logic [TAB_AW-1:0] tab_index(input logic signed [15:0] x, input int frac);
    logic signed [31:0] t;
    t = 32'(x) + (32'sd8 <<< frac);
    if (t < 0) begin
      return '0;
    end
    t = t >>> (frac - 6);
    if (t > 32'sd1023) begin
      return 10'd1023;
    end
    return t[TAB_AW-1:0];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] qt;
    int b;
    r = '0;
    qt = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        qt[b] = 1'b1;
      end
    end
    return qt;
  endfunction

  function automatic tab_t build_tab(input int frac, input bit is_tanh);
    tab_t        tb;
    logic [31:0] ex [EXP_N];
    logic [63:0] p;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] r;
    int          m;
    int          k;
    int          d;
    int          a;
    ex[0] = 32'h8000_0000;
    for (m = 1; m < EXP_N; m++) begin
      p = 64'(ex[m-1]) * 64'(EXP_STEP) + (ONE31 >> 1);
      ex[m] = p[62:31];
    end
    for (k = 0; k < TAB_N; k++) begin
      d = 2 * k - 1023;
      a = (d < 0) ? -d : d;
      if (!is_tanh) begin
        e = 64'(ex[a]);
        den = ONE31 + e;
        num = (d < 0) ? (e << frac) : (ONE31 << frac);
        r = udiv64(num + (den >> 1), den);
        tb[k] = r[15:0];
      end else begin
        e = 64'(ex[2*a]);
        den = ONE31 + e;
        num = ((ONE31 - e) << frac) + (den >> 1);
        r = udiv64(num, den);
        tb[k] = (d < 0) ? -r[15:0] : r[15:0];
      end
    end
    return tb;
  endfunction

endpackage

/* rtl/lstmp_dp.sv */
`timescale 1ns / 1ps
module lstmp_dp #(
  parameter int MAX_INPUT  = lstmp_pkg::MAX_INPUT_DEF,
  parameter int MAX_HIDDEN = lstmp_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_PROJ   = lstmp_pkg::MAX_PROJ_DEF,
  parameter int FRAC_BITS  = lstmp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lstmp_pkg::cmd_t                     cmd_i,
  input  logic [2:0]                          func_i,
  input  logic [lstmp_pkg::IDX_W-1:0]         index_i,
  input  logic signed [lstmp_pkg::VAL_W-1:0]  value_i,
  output lstmp_pkg::sts_t                     sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lstmp_pkg::VAL_W-1:0]  out_value_o,
  output logic [lstmp_pkg::OIDX_W-1:0]        out_index_o,
  output logic                                out_last_o
);

  localparam int IW_D  = 4 * MAX_HIDDEN * MAX_INPUT;
  localparam int RW_D  = 4 * MAX_HIDDEN * MAX_PROJ;
  localparam int PW_D  = MAX_PROJ * MAX_HIDDEN;
  localparam int B_D   = 4 * MAX_HIDDEN;
  localparam int IW_AW = $clog2(IW_D);
  localparam int RW_AW = $clog2(RW_D);
  localparam int PW_AW = (PW_D > 1) ? $clog2(PW_D) : 1;
  localparam int B_AW  = $clog2(B_D);
  localparam int S_AW  = (MAX_INPUT > 1) ? $clog2(MAX_INPUT) : 1;
  localparam int C_AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int P_AW  = (MAX_PROJ > 1) ? $clog2(MAX_PROJ) : 1;
  localparam int ACC_W = lstmp_pkg::ACC_W;

  localparam lstmp_pkg::tab_t SIG_TAB  = lstmp_pkg::build_tab(FRAC_BITS, 1'b0);
  localparam lstmp_pkg::tab_t TANH_TAB = lstmp_pkg::build_tab(FRAC_BITS, 1'b1);

  logic signed [15:0] iw_mem   [IW_D];
  logic signed [15:0] rw_mem   [RW_D];
  logic signed [15:0] pw_mem   [PW_D];
  logic signed [15:0] b_mem    [B_D];
  logic signed [15:0] s_mem    [MAX_INPUT];
  logic signed [15:0] cell_mem [MAX_HIDDEN];
  logic signed [15:0] ps_mem   [MAX_PROJ];
  logic signed [15:0] h_mem    [MAX_HIDDEN];

  logic [MAX_HIDDEN-1:0] cell_v_q;
  logic [MAX_PROJ-1:0]   ps_v_q;

  logic signed [15:0] iw_rd_q, rw_rd_q, pw_rd_q, b_rd_q, s_rd_q;
  logic signed [15:0] cell_rd_q, ps_rd_q, h_rd_q;
  logic               cell_vrd_q, ps_vrd_q, rd_ok_q;

  lstmp_pkg::cmd_t    cmd_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0] pre_q [4];
  logic signed [15:0] act_q [4];
  logic signed [15:0] c_q, tc_q;

  logic               out_valid_q;
  logic signed [15:0] out_value_q;
  logic [lstmp_pkg::OIDX_W-1:0] out_index_q;
  logic               out_last_q;

  logic [31:0] idx32, row32, i32, q32, u32, ridx32, uq32, qq32;
  logic [31:0] iw_ra, rw_ra, pw_ra;
  logic [C_AW-1:0] ca;
  logic signed [15:0] ma, mb, cell_val, ps_val, rnd;
  logic signed [31:0] prod;
  logic wr_iw, wr_rw, wr_pw, wr_b, wr_s, wr_c, wr_p;

  assign idx32  = 32'(index_i);
  assign i32    = 32'(cmd_i.i);
  assign q32    = 32'(cmd_i.q);
  assign u32    = 32'(cmd_i.u);
  assign ridx32 = 32'(cmd_i.ridx);
  assign uq32   = 32'(cmd_q.u);
  assign qq32   = 32'(cmd_q.q);
  assign row32  = 32'(cmd_i.g) * 32'(MAX_HIDDEN) + u32;
  assign iw_ra  = row32 * 32'(MAX_INPUT) + i32;
  assign rw_ra  = row32 * 32'(MAX_PROJ) + i32;
  assign pw_ra  = q32 * 32'(MAX_HIDDEN) + i32;
  assign ca     = (cmd_i.op == lstmp_pkg::OP_RD_CELL) ? ridx32[C_AW-1:0] : u32[C_AW-1:0];

  assign wr_iw = cmd_i.wr && (func_i == lstmp_pkg::FN_IN_W)   && (idx32 < 32'(IW_D));
  assign wr_rw = cmd_i.wr && (func_i == lstmp_pkg::FN_REC_W)  && (idx32 < 32'(RW_D));
  assign wr_pw = cmd_i.wr && (func_i == lstmp_pkg::FN_PROJ_W) && (idx32 < 32'(PW_D));
  assign wr_b  = cmd_i.wr && (func_i == lstmp_pkg::FN_BIAS)   && (idx32 < 32'(B_D));
  assign wr_s  = cmd_i.wr && (func_i == lstmp_pkg::FN_SAMPLE) && (idx32 < 32'(MAX_INPUT));
  assign wr_c  = cmd_i.wr && (func_i == lstmp_pkg::FN_INIT_C) && (idx32 < 32'(MAX_HIDDEN));
  assign wr_p  = cmd_i.wr && (func_i == lstmp_pkg::FN_INIT_P) && (idx32 < 32'(MAX_PROJ));

  always_ff @(posedge clk_i) begin
    if (wr_iw) begin
      iw_mem[idx32[IW_AW-1:0]] <= value_i;
    end
    iw_rd_q <= iw_mem[iw_ra[IW_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_rw) begin
      rw_mem[idx32[RW_AW-1:0]] <= value_i;
    end
    rw_rd_q <= rw_mem[rw_ra[RW_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_pw) begin
      pw_mem[idx32[PW_AW-1:0]] <= value_i;
    end
    pw_rd_q <= pw_mem[pw_ra[PW_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      b_mem[idx32[B_AW-1:0]] <= value_i;
    end
    b_rd_q <= b_mem[row32[B_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_s) begin
      s_mem[idx32[S_AW-1:0]] <= value_i;
    end
    s_rd_q <= s_mem[i32[S_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.op == lstmp_pkg::OP_SAVE_C) begin
      cell_mem[uq32[C_AW-1:0]] <= rnd;
    end else if (wr_c) begin
      cell_mem[idx32[C_AW-1:0]] <= value_i;
    end
    cell_rd_q <= cell_mem[ca];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.op == lstmp_pkg::OP_SAVE_Y) begin
      ps_mem[qq32[P_AW-1:0]] <= rnd;
    end else if (wr_p) begin
      ps_mem[idx32[P_AW-1:0]] <= value_i;
    end
    ps_rd_q <= ps_mem[i32[P_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.op == lstmp_pkg::OP_SAVE_H) begin
      h_mem[uq32[C_AW-1:0]] <= rnd;
    end
    h_rd_q <= h_mem[i32[C_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_v_q   <= '0;
      ps_v_q     <= '0;
      cell_vrd_q <= 1'b0;
      ps_vrd_q   <= 1'b0;
      rd_ok_q    <= 1'b0;
      cmd_q      <= '0;
    end else begin
      if (cmd_q.op == lstmp_pkg::OP_SAVE_C) begin
        cell_v_q[uq32[C_AW-1:0]] <= 1'b1;
      end else if (wr_c) begin
        cell_v_q[idx32[C_AW-1:0]] <= 1'b1;
      end
      if (cmd_q.op == lstmp_pkg::OP_SAVE_Y) begin
        ps_v_q[qq32[P_AW-1:0]] <= 1'b1;
      end else if (wr_p) begin
        ps_v_q[idx32[P_AW-1:0]] <= 1'b1;
      end
      cell_vrd_q <= cell_v_q[ca];
      ps_vrd_q   <= ps_v_q[i32[P_AW-1:0]];
      rd_ok_q    <= ridx32 < 32'(MAX_HIDDEN);
      cmd_q      <= cmd_i;
    end
  end

  assign cell_val = cell_vrd_q ? cell_rd_q : '0;
  assign ps_val   = ps_vrd_q ? ps_rd_q : '0;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_q.op)
      lstmp_pkg::OP_MAC_IN:  begin ma = iw_rd_q;  mb = s_rd_q;   end
      lstmp_pkg::OP_MAC_REC: begin ma = rw_rd_q;  mb = ps_val;   end
      lstmp_pkg::OP_CELL_A:  begin ma = act_q[1]; mb = cell_val; end
      lstmp_pkg::OP_CELL_B:  begin ma = act_q[0]; mb = act_q[3]; end
      lstmp_pkg::OP_HID:     begin ma = act_q[2]; mb = tc_q;     end
      lstmp_pkg::OP_MAC_PW:  begin ma = h_rd_q;   mb = pw_rd_q;  end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign rnd  = lstmp_pkg::sat_round(acc_q, FRAC_BITS);

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_q.op)
      lstmp_pkg::OP_BIAS:    acc_d = ACC_W'(b_rd_q) <<< FRAC_BITS;
      lstmp_pkg::OP_MAC_IN,
      lstmp_pkg::OP_MAC_REC,
      lstmp_pkg::OP_CELL_B:  acc_d = acc_q + ACC_W'(prod);
      lstmp_pkg::OP_CELL_A,
      lstmp_pkg::OP_HID:     acc_d = ACC_W'(prod);
      lstmp_pkg::OP_MAC_PW:  acc_d = (cmd_q.i == '0) ? ACC_W'(prod) : acc_q + ACC_W'(prod);
      default:               acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_q.op == lstmp_pkg::OP_SAVE_PRE) begin
      pre_q[cmd_q.g] <= rnd;
    end
    if (cmd_q.op == lstmp_pkg::OP_LUT) begin
      act_q[cmd_q.g] <= (cmd_q.g == 2'd3) ?
          TANH_TAB[lstmp_pkg::tab_index(pre_q[cmd_q.g], FRAC_BITS)] :
          SIG_TAB[lstmp_pkg::tab_index(pre_q[cmd_q.g], FRAC_BITS)];
    end
    if (cmd_q.op == lstmp_pkg::OP_SAVE_C) begin
      c_q <= rnd;
    end
    if (cmd_q.op == lstmp_pkg::OP_TANH_C) begin
      tc_q <= TANH_TAB[lstmp_pkg::tab_index(c_q, FRAC_BITS)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_q.op == lstmp_pkg::OP_SAVE_Y || cmd_q.op == lstmp_pkg::OP_RD_CELL) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.op == lstmp_pkg::OP_SAVE_Y) begin
      out_value_q <= rnd;
      out_index_q <= cmd_q.q[lstmp_pkg::OIDX_W-1:0];
      out_last_q  <= cmd_q.lst;
    end else if (cmd_q.op == lstmp_pkg::OP_RD_CELL) begin
      out_value_q <= rd_ok_q ? cell_val : '0;
      out_index_q <= cmd_q.ridx[lstmp_pkg::OIDX_W-1:0];
      out_last_q  <= 1'b1;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_index_o    = out_index_q;
  assign out_last_o     = out_last_q;

endmodule

/* rtl/lstmp_ctrl.sv */
`timescale 1ns / 1ps
module lstmp_ctrl #(
  parameter int MAX_INPUT  = lstmp_pkg::MAX_INPUT_DEF,
  parameter int MAX_HIDDEN = lstmp_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_PROJ   = lstmp_pkg::MAX_PROJ_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  func_i,
  input  logic [lstmp_pkg::IDX_W-1:0] index_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [lstmp_pkg::CNT_W-1:0] cfg_wdata_i,
  input  lstmp_pkg::sts_t             sts_i,
  output lstmp_pkg::cmd_t             cmd_o
);

  localparam int CW = lstmp_pkg::CNT_W;

  lstmp_pkg::state_e st_q, st_d;
  logic [CW-1:0] in_cnt_q, hid_cnt_q, prj_cnt_q;
  logic [CW-1:0] n_in, n_hid, n_prj;
  logic [1:0]    g_q, g_d;
  logic [CW-1:0] u_q, u_d, i_q, i_d, q_q, q_d;
  logic [lstmp_pkg::IDX_W-1:0] ridx_q, ridx_d;
  logic          acc_in;

  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] v, input int mx);
    if (v == '0) begin
      return CW'(1);
    end else if (32'(v) > 32'(mx)) begin
      return CW'(mx);
    end
    return v;
  endfunction

  assign n_in  = clamp_cnt(in_cnt_q, MAX_INPUT);
  assign n_hid = clamp_cnt(hid_cnt_q, MAX_HIDDEN);
  assign n_prj = clamp_cnt(prj_cnt_q, MAX_PROJ);

  assign in_ready_o = (st_q == lstmp_pkg::ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= CW'(64);
      hid_cnt_q <= CW'(64);
      prj_cnt_q <= CW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lstmp_pkg::REG_INPUT:  in_cnt_q  <= cfg_wdata_i;
        lstmp_pkg::REG_HIDDEN: hid_cnt_q <= cfg_wdata_i;
        lstmp_pkg::REG_PROJ:   prj_cnt_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= lstmp_pkg::ST_IDLE;
      g_q    <= '0;
      u_q    <= '0;
      i_q    <= '0;
      q_q    <= '0;
      ridx_q <= '0;
    end else begin
      st_q   <= st_d;
      g_q    <= g_d;
      u_q    <= u_d;
      i_q    <= i_d;
      q_q    <= q_d;
      ridx_q <= ridx_d;
    end
  end

  always_comb begin
    st_d   = st_q;
    g_d    = g_q;
    u_d    = u_q;
    i_d    = i_q;
    q_d    = q_q;
    ridx_d = ridx_q;
    cmd_o      = '0;
    cmd_o.op   = lstmp_pkg::OP_NONE;
    cmd_o.g    = g_q;
    cmd_o.u    = u_q;
    cmd_o.i    = i_q;
    cmd_o.q    = q_q;
    cmd_o.ridx = ridx_q;
    unique case (st_q)
      lstmp_pkg::ST_IDLE: begin
        cmd_o.wr = acc_in;
        if (acc_in) begin
          if (func_i == lstmp_pkg::FN_SAMPLE && last_i) begin
            g_d  = '0;
            u_d  = '0;
            i_d  = '0;
            st_d = lstmp_pkg::ST_BIAS;
          end else if (func_i == lstmp_pkg::FN_READ_C) begin
            ridx_d = index_i;
            st_d   = lstmp_pkg::ST_RDC;
          end
        end
      end
      lstmp_pkg::ST_RDC: begin
        if (!sts_i.out_full) begin
          cmd_o.op = lstmp_pkg::OP_RD_CELL;
          st_d     = lstmp_pkg::ST_IDLE;
        end
      end
      lstmp_pkg::ST_BIAS: begin
        cmd_o.op = lstmp_pkg::OP_BIAS;
        i_d      = '0;
        st_d     = lstmp_pkg::ST_IN;
      end
      lstmp_pkg::ST_IN: begin
        cmd_o.op = lstmp_pkg::OP_MAC_IN;
        if (i_q == n_in - CW'(1)) begin
          i_d  = '0;
          st_d = lstmp_pkg::ST_REC;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      lstmp_pkg::ST_REC: begin
        cmd_o.op = lstmp_pkg::OP_MAC_REC;
        if (i_q == n_prj - CW'(1)) begin
          i_d  = '0;
          st_d = lstmp_pkg::ST_GSAV;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      lstmp_pkg::ST_GSAV: begin
        cmd_o.op = lstmp_pkg::OP_SAVE_PRE;
        g_d      = g_q + 2'd1;
        st_d     = (g_q == 2'd3) ? lstmp_pkg::ST_ACT : lstmp_pkg::ST_BIAS;
      end
      lstmp_pkg::ST_ACT: begin
        cmd_o.op = lstmp_pkg::OP_LUT;
        g_d      = g_q + 2'd1;
        if (g_q == 2'd3) begin
          st_d = lstmp_pkg::ST_CA;
        end
      end
      lstmp_pkg::ST_CA: begin
        cmd_o.op = lstmp_pkg::OP_CELL_A;
        st_d     = lstmp_pkg::ST_CB;
      end
      lstmp_pkg::ST_CB: begin
        cmd_o.op = lstmp_pkg::OP_CELL_B;
        st_d     = lstmp_pkg::ST_CSAV;
      end
      lstmp_pkg::ST_CSAV: begin
        cmd_o.op = lstmp_pkg::OP_SAVE_C;
        st_d     = lstmp_pkg::ST_TC;
      end
      lstmp_pkg::ST_TC: begin
        cmd_o.op = lstmp_pkg::OP_TANH_C;
        st_d     = lstmp_pkg::ST_HID;
      end
      lstmp_pkg::ST_HID: begin
        cmd_o.op = lstmp_pkg::OP_HID;
        st_d     = lstmp_pkg::ST_HSAV;
      end
      lstmp_pkg::ST_HSAV: begin
        cmd_o.op = lstmp_pkg::OP_SAVE_H;
        g_d      = '0;
        if (u_q == n_hid - CW'(1)) begin
          u_d  = '0;
          st_d = lstmp_pkg::ST_PGAP;
        end else begin
          u_d  = u_q + CW'(1);
          st_d = lstmp_pkg::ST_BIAS;
        end
      end
      lstmp_pkg::ST_PGAP: begin
        i_d  = '0;
        q_d  = '0;
        st_d = lstmp_pkg::ST_PMAC;
      end
      lstmp_pkg::ST_PMAC: begin
        cmd_o.op = lstmp_pkg::OP_MAC_PW;
        if (i_q == n_hid - CW'(1)) begin
          i_d  = '0;
          st_d = lstmp_pkg::ST_PSAV;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      lstmp_pkg::ST_PSAV: begin
        if (!sts_i.out_full) begin
          cmd_o.op  = lstmp_pkg::OP_SAVE_Y;
          cmd_o.lst = (q_q == n_prj - CW'(1));
          if (q_q == n_prj - CW'(1)) begin
            q_d  = '0;
            st_d = lstmp_pkg::ST_FIN;
          end else begin
            q_d  = q_q + CW'(1);
            st_d = lstmp_pkg::ST_PMAC;
          end
        end
      end
      lstmp_pkg::ST_FIN: begin
        st_d = lstmp_pkg::ST_IDLE;
      end
      default: begin
        st_d = lstmp_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q == lstmp_pkg::ST_BIAS && $past(st_q) == lstmp_pkg::ST_IDLE) |->
      $past(in_valid_i && in_ready_o && func_i == lstmp_pkg::FN_SAMPLE && last_i))
    else $error("step started without a last sample beat");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_o.op == lstmp_pkg::OP_SAVE_Y || cmd_o.op == lstmp_pkg::OP_RD_CELL) |->
      !sts_i.out_full)
    else $error("result issued into a full output register");
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q != lstmp_pkg::ST_IDLE) |-> (u_q < n_hid && q_q < n_prj))
    else $error("unit or output counter out of range");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.wr |-> (st_q == lstmp_pkg::ST_IDLE))
    else $error("store write outside idle");
`endif

endmodule

/* rtl/lstm_projection_step.sv */
`timescale 1ns / 1ps
// Write and sample beats without last leave the block idle. Cell read: the read state waits
// while the output register is full, then the result is registered out. A step (sample with
// last) runs on one shared multiply-accumulate unit; the next beat waits for it.
// Results leave through a single output register; a stalled output holds the step.
// Reset (async, active low): counts return to 64, cell and projected state read as zero,
// weight, bias and sample stores hold whatever is written and need no clearing pass.
module lstm_projection_step #(
  parameter int MAX_INPUT  = lstmp_pkg::MAX_INPUT_DEF,
  parameter int MAX_HIDDEN = lstmp_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_PROJ   = lstmp_pkg::MAX_PROJ_DEF,
  parameter int FRAC_BITS  = lstmp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          func_i,
  input  logic [lstmp_pkg::IDX_W-1:0]         index_i,
  input  logic signed [lstmp_pkg::VAL_W-1:0]  value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lstmp_pkg::VAL_W-1:0]  out_value_o,
  output logic [lstmp_pkg::OIDX_W-1:0]        out_index_o,
  output logic                                out_last_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [lstmp_pkg::CNT_W-1:0]         cfg_wdata_i
);

  lstmp_pkg::cmd_t cmd;
  lstmp_pkg::sts_t sts;

  lstmp_ctrl #(
    .MAX_INPUT  (MAX_INPUT),
    .MAX_HIDDEN (MAX_HIDDEN),
    .MAX_PROJ   (MAX_PROJ)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .last_i      (last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lstmp_dp #(
    .MAX_INPUT  (MAX_INPUT),
    .MAX_HIDDEN (MAX_HIDDEN),
    .MAX_PROJ   (MAX_PROJ),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .out_index_o (out_index_o),
    .out_last_o  (out_last_o)
  );

endmodule
